// File: design/spq_pkg.sv
// spq_pkg: shared types and constants for the stable priority queue
// used by spq_cell and stable_priority_queue_top; depends on nothing
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// one stored entry of the chain
	typedef struct packed {
		logic        valid;
		logic [7:0]  pri;
		logic [7:0]  age;
		logic [15:0] tag;
	} entry_t;

	// operation broadcast to every cell in the accepting cycle
	typedef struct packed {
		logic        enq;
		logic        deq;
		logic [7:0]  pri;
		logic [7:0]  age;
		logic [15:0] tag;
	} ctrl_t;

endpackage

// File: design/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds an entry and shifts with its neighbors
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  spq_pkg::ctrl_t ctrl,
	input  spq_pkg::entry_t left_entry,
	input  logic           left_greater,
	input  spq_pkg::entry_t right_entry,
	output spq_pkg::entry_t entry,
	output logic           greater
);

	logic        valid_q;
	logic [7:0]  pri_q;
	logic [7:0]  age_q;
	logic [15:0] tag_q;
	spq_pkg::entry_t next_entry;
	logic        load;

	assign entry = '{valid: valid_q, pri: pri_q, age: age_q, tag: tag_q};

	// an empty slot counts as holding an infinite priority
	assign greater = !valid_q || (pri_q > ctrl.pri);

	always_comb begin
		next_entry = entry;
		load       = 1'b0;
		priority if (ctrl.deq) begin
			next_entry = right_entry;
			load       = 1'b1;
		end else if (ctrl.enq && left_greater) begin
			next_entry = left_entry;
			load       = 1'b1;
		end else if (ctrl.enq && greater) begin
			next_entry = '{valid: 1'b1, pri: ctrl.pri, age: ctrl.age, tag: ctrl.tag};
			load       = 1'b1;
		end else begin
			load       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= next_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pri_q <= next_entry.pri;
			age_q <= next_entry.age;
			tag_q <= next_entry.tag;
		end
	end

endmodule

// File: design/stable_priority_queue_top.sv
// channel  | valid    | stall     | payload
// input    | in_valid | in_stall  | action, priority_req, age, name_tag
// output   | out_valid| out_stall | status, out_priority, out_age, out_name_tag
//
// one item per cycle while in_stall is low: every cell compares against the new priority at once and
// shifts by one slot, so the chain update finishes in the accepting cycle
// the result is held in the output register from the cycle after acceptance
// in_stall is high only while a result waits in that register and out_stall is high
// reset clears every slot's valid bit and the output valid; no clearing pass
// top level: instantiates DEPTH spq_cell slots; depends on spq_pkg
`timescale 1ns / 1ps

module stable_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  priority_req,
	input  logic [7:0]  age,
	input  logic [15:0] name_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  out_priority,
	output logic [7:0]  out_age,
	output logic [15:0] out_name_tag
);

	spq_pkg::entry_t entries [DEPTH];
	logic [DEPTH-1:0] greater;
	logic [DEPTH-1:0] valid_vec;
	spq_pkg::ctrl_t   ctrl;
	logic             accept;
	logic             full;
	logic             empty;

	logic             out_valid_q;
	spq_pkg::status_t status_q;
	logic [7:0]       pri_q;
	logic [7:0]       age_q;
	logic [15:0]      tag_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = entries[DEPTH-1].valid;
	assign empty    = !entries[0].valid;

	assign ctrl = '{
		enq: accept && !action && !full,
		deq: accept && action && !empty,
		pri: priority_req,
		age: age,
		tag: name_tag
	};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_g;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_g = greater[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_entry  (left_e),
			.left_greater(left_g),
			.right_entry (right_e),
			.entry       (entries[i]),
			.greater     (greater[i])
		);

		assign valid_vec[i] = entries[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pri_q <= '0;
			age_q <= '0;
			tag_q <= '0;
			unique case ({action, full, empty})
				3'b000, 3'b001: status_q <= spq_pkg::ST_ENQUEUED;
				3'b010, 3'b011: status_q <= spq_pkg::ST_FULL;
				3'b101, 3'b111: status_q <= spq_pkg::ST_EMPTY;
				default: begin
					status_q <= spq_pkg::ST_DEQUEUED;
					pri_q    <= entries[0].pri;
					age_q    <= entries[0].age;
					tag_q    <= entries[0].tag;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = pri_q;
	assign out_age      = age_q;
	assign out_name_tag = tag_q;

`ifndef SYNTH
	// occupied slots always form a run from the head
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + 1'b1) & valid_vec) == '0)
		else $error("queue slots not contiguous from head");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
		else $error("enqueue did not add exactly one entry");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.deq |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec)))
			&& status == spq_pkg::ST_DEQUEUED)
		else $error("dequeue beat mismatch");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.enq && !ctrl.deq |=> $stable(valid_vec))
		else $error("chain changed without an operation");
`endif

endmodule
